// ===== rtl/tcol_pkg.sv =====
// Shared types and constants for the tile occupancy chain store.
package tcol_pkg;

    localparam int TILES       = 32768;
    localparam int MAX_OBJECTS = 1024;

    localparam int TILE_W = 15;
    localparam int ID_W   = 10;
    localparam int STEP_W = $clog2(MAX_OBJECTS) + 1;

    typedef enum logic [1:0] {
        CMD_TEST   = 2'd0,
        CMD_READ   = 2'd1,
        CMD_APPEND = 2'd2,
        CMD_UNLINK = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_IGNORED   = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD,
        ST_WALK_APPEND,
        ST_WALK_UNLINK,
        ST_UNLINK_HEAD,
        ST_UNLINK_MID,
        ST_UNLINK_END
    } state_t;

endpackage

// ===== rtl/tile_chained_occupancy_lists.sv =====
// Tile occupancy chains: head table and next-link table with a chain-walking sequencer.
//
//  channel   | ports                          | handshake
//  ----------+--------------------------------+-------------------------------------
//  command   | command, tile, object_id       | taken on start while busy is low
//  result    | head_object, occupied, status  | done high for one cycle, no stall
//
//  Test, read, ignored words and an append to an empty tile end at the head read.
//  An append follows the links to the tail (at most MAX_OBJECTS of them); an unlink
//  at the head ends there, else it walks the chain to the predecessor and relinks.
//  Each link costs one read of the next-link memory, whose registered data returns in the following cycle.
//  After reset both memories are cleared by a pass over all TILES (32768) head entries,
//  one entry a cycle, with busy high; the result side cannot stall and needs no skid.
module tile_chained_occupancy_lists
    import tcol_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [TILE_W-1:0] tile,
    input  logic [ID_W-1:0]   object_id,
    output logic              done,
    output logic [ID_W-1:0]   head_object,
    output logic              occupied,
    output logic [1:0]        status
);

    // Memories: one head per tile, one next link per object
    logic [ID_W-1:0] heads_mem [TILES];
    logic [ID_W-1:0] links_mem [MAX_OBJECTS];

    state_t            state_reg, state_next;
    logic [TILE_W-1:0] clr_cnt_reg, clr_cnt_next;

    // Latched command word
    command_t          cmd_reg;
    logic [TILE_W-1:0] tile_reg;
    logic [ID_W-1:0]   id_reg;
    logic              tile_ok_reg;
    logic              id_ok_reg;

    // Walk state
    logic [ID_W-1:0]   head_reg, head_next;
    logic [ID_W-1:0]   cur_reg, cur_next;
    logic [STEP_W-1:0] steps_reg, steps_next;

    // Result register
    logic              done_reg;
    logic [ID_W-1:0]   res_head_reg;
    status_t           res_status_reg;
    logic              fin;
    logic [ID_W-1:0]   res_head;
    status_t           res_status;

    // Memory ports
    logic              heads_we, heads_re;
    logic [TILE_W-1:0] heads_waddr, heads_raddr;
    logic [ID_W-1:0]   heads_wdata, heads_rdata_reg;
    logic              links_we, links_re;
    logic [ID_W-1:0]   links_waddr, links_raddr, links_wdata, links_rdata_reg;

    logic              accept;
    logic              in_tile_ok, in_id_ok;
    logic              at_limit;

    assign accept     = start && !busy;
    assign in_tile_ok = 32'(tile) < TILES;
    assign in_id_ok   = (object_id != '0) && (32'(object_id) < MAX_OBJECTS);
    assign at_limit   = steps_reg == STEP_W'(MAX_OBJECTS);

    assign busy        = state_reg != ST_IDLE;
    assign done        = done_reg;
    assign head_object = res_head_reg;
    assign occupied    = res_head_reg != '0;
    assign status      = res_status_reg;

    always_ff @(posedge clk)
    begin
        if (heads_we)
        begin
            heads_mem[heads_waddr] <= heads_wdata;
        end
        if (heads_re)
        begin
            heads_rdata_reg <= heads_mem[heads_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (links_we)
        begin
            links_mem[links_waddr] <= links_wdata;
        end
        if (links_re)
        begin
            links_rdata_reg <= links_mem[links_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= fin;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= command_t'(command);
            tile_reg    <= tile;
            id_reg      <= object_id;
            tile_ok_reg <= in_tile_ok;
            id_ok_reg   <= in_id_ok;
        end
        head_reg  <= head_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        if (fin)
        begin
            res_head_reg   <= res_head;
            res_status_reg <= res_status;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        head_next    = head_reg;
        cur_next     = cur_reg;
        steps_next   = steps_reg;
        fin          = 1'b0;
        res_head     = head_reg;
        res_status   = STATUS_DONE;
        heads_we     = 1'b0;
        heads_waddr  = tile_reg;
        heads_wdata  = '0;
        heads_re     = 1'b0;
        heads_raddr  = tile;
        links_we     = 1'b0;
        links_waddr  = id_reg;
        links_wdata  = '0;
        links_re     = 1'b0;
        links_raddr  = links_rdata_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep both tables to zero, one entry a cycle
                heads_we    = 1'b1;
                heads_waddr = clr_cnt_reg;
                links_we    = 32'(clr_cnt_reg) < MAX_OBJECTS;
                links_waddr = clr_cnt_reg[ID_W-1:0];
                clr_cnt_next = TILE_W'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == TILE_W'(TILES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    heads_re    = 1'b1;
                    heads_raddr = tile;
                    // Append drops the object's own link before anything else
                    if (in_tile_ok && in_id_ok && command_t'(command) == CMD_APPEND)
                    begin
                        links_we    = 1'b1;
                        links_waddr = object_id;
                        links_wdata = '0;
                    end
                    state_next = ST_HEAD;
                end
            end

            ST_HEAD:
            begin
                head_next  = heads_rdata_reg;
                steps_next = '0;
                cur_next   = heads_rdata_reg;
                if (!tile_ok_reg)
                begin
                    fin        = 1'b1;
                    res_head   = '0;
                    res_status = STATUS_IGNORED;
                    state_next = ST_IDLE;
                end
                else if (cmd_reg == CMD_TEST || cmd_reg == CMD_READ)
                begin
                    fin        = 1'b1;
                    res_head   = heads_rdata_reg;
                    state_next = ST_IDLE;
                end
                else if (!id_ok_reg)
                begin
                    fin        = 1'b1;
                    res_head   = heads_rdata_reg;
                    res_status = STATUS_IGNORED;
                    state_next = ST_IDLE;
                end
                else if (cmd_reg == CMD_APPEND)
                begin
                    if (heads_rdata_reg == '0)
                    begin
                        heads_we    = 1'b1;
                        heads_wdata = id_reg;
                        fin         = 1'b1;
                        res_head    = id_reg;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        links_re    = 1'b1;
                        links_raddr = heads_rdata_reg;
                        state_next  = ST_WALK_APPEND;
                    end
                end
                else
                begin
                    if (heads_rdata_reg == '0)
                    begin
                        fin        = 1'b1;
                        res_head   = '0;
                        res_status = STATUS_NOT_FOUND;
                        state_next = ST_IDLE;
                    end
                    else if (heads_rdata_reg == id_reg)
                    begin
                        links_re    = 1'b1;
                        links_raddr = id_reg;
                        state_next  = ST_UNLINK_HEAD;
                    end
                    else
                    begin
                        links_re    = 1'b1;
                        links_raddr = heads_rdata_reg;
                        state_next  = ST_WALK_UNLINK;
                    end
                end
            end

            ST_WALK_APPEND:
            begin
                // Read data is the link of cur_reg
                if (links_rdata_reg != '0 && !at_limit)
                begin
                    cur_next    = links_rdata_reg;
                    steps_next  = STEP_W'(steps_reg + 1'b1);
                    links_re    = 1'b1;
                    links_raddr = links_rdata_reg;
                end
                else
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                    if (links_rdata_reg != '0)
                    begin
                        // Cyclic chain: no tail found within the limit
                        res_status = STATUS_IGNORED;
                    end
                    else
                    begin
                        links_we    = 1'b1;
                        links_waddr = cur_reg;
                        links_wdata = id_reg;
                    end
                end
            end

            ST_WALK_UNLINK:
            begin
                // Read data is the link of the predecessor candidate in cur_reg
                if (links_rdata_reg == id_reg)
                begin
                    links_re    = 1'b1;
                    links_raddr = id_reg;
                    state_next  = ST_UNLINK_MID;
                end
                else if (links_rdata_reg == '0 || at_limit)
                begin
                    fin        = 1'b1;
                    res_status = STATUS_NOT_FOUND;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next    = links_rdata_reg;
                    steps_next  = STEP_W'(steps_reg + 1'b1);
                    links_re    = 1'b1;
                    links_raddr = links_rdata_reg;
                end
            end

            ST_UNLINK_HEAD:
            begin
                // Head takes over the object's link, then the object's link is dropped
                heads_we    = 1'b1;
                heads_wdata = links_rdata_reg;
                links_we    = 1'b1;
                links_waddr = id_reg;
                links_wdata = '0;
                fin         = 1'b1;
                res_head    = links_rdata_reg;
                state_next  = ST_IDLE;
            end

            ST_UNLINK_MID:
            begin
                links_we    = 1'b1;
                links_waddr = cur_reg;
                links_wdata = links_rdata_reg;
                state_next  = ST_UNLINK_END;
            end

            ST_UNLINK_END:
            begin
                links_we    = 1'b1;
                links_waddr = id_reg;
                links_wdata = '0;
                fin         = 1'b1;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted word did not make the block busy");

    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results on consecutive cycles");

    a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (occupied == (head_object != '0)))
        else $error("occupied disagrees with head_object");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STATUS_DONE || status == STATUS_IGNORED
                  || status == STATUS_NOT_FOUND))
        else $error("undefined status code");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_APPEND || state_reg == ST_WALK_UNLINK)
            |-> (32'(steps_reg) <= MAX_OBJECTS))
        else $error("walk ran past the link limit");
`endif

endmodule
